FILE: rtl/fa25519_pkg.sv
// Shared types and constants for the 2^255-19 field arithmetic unit.
// No dependencies; imported by every module of the block.
package fa25519_pkg;

    localparam int unsigned NLIMB  = 5;
    localparam int unsigned LIMB_W = 51;
    localparam int unsigned IN_W   = 54;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned JOIN_W = 259;   // integer value of an unreduced operand
    localparam int unsigned Y_W    = 260;   // multiplier word, scanned by the cell row
    localparam int unsigned X_W    = 256;   // partly reduced multiplicand
    localparam int unsigned ACC_W  = 262;   // running sum inside the cell row
    localparam int unsigned DIG_W  = 4;     // multiplier bits consumed per cell
    localparam int unsigned NCELL  = Y_W / DIG_W;
    localparam int unsigned FOLD   = 19;    // 2^255 == 19 (mod p)

    localparam logic [X_W-1:0] P_VAL     = (256'd1 << 255) - 256'd19;
    localparam logic [Y_W-1:0] SIXTEEN_P = (260'd1 << 259) - 260'd304;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_SQR = 3'd3,
        OP_RED = 3'd4
    } op_t;

    typedef logic [NLIMB-1:0][IN_W-1:0] limbs_in_t;

    // Token handed from cell to cell
    typedef struct packed {
        logic [X_W-1:0]   x;
        logic [ACC_W-1:0] acc;
        logic [Y_W-1:0]   y;
    } fa_tok_t;

endpackage

FILE: rtl/field_alu_mod_p25519_core.sv
// Channel   Dir  tdata bits  Fields (lowest bit up)
// s_axis    in   544         op[2:0], a_limb0..4 (54 each), b_limb0..4 (54 each), pad
// m_axis    out  256         r_limb0..4 (51 each), pad
//
// One transfer in per cycle sustained while the output is not stalled; results pass
// through the prep stages, the row of 65 cells, each taking four multiplier bits, and canon.
// Every stage is elastic: a stalled output fills the bubbles upstream, and
// s_tready drops only when every stage holds an item.
// aresetn clears all stage valid bits; no clearing pass is needed.
module field_alu_mod_p25519_core
    import fa25519_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [543:0] s_tdata,   // op, a_limb0..a_limb4, b_limb0..b_limb4, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // r_limb0..r_limb4, zero pad
);

    logic            vld_w [NCELL+1];
    logic            rdy_w [NCELL+1];
    fa_tok_t         tok_w [NCELL+1];
    limbs_in_t       a_in, b_in;
    logic [254:0]    r;

    assign a_in = s_tdata[OP_W +: NLIMB*IN_W];
    assign b_in = s_tdata[OP_W + NLIMB*IN_W +: NLIMB*IN_W];

    fa25519_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[OP_W-1:0]),
        .in_a      (a_in),
        .in_b      (b_in),
        .out_valid (vld_w[0]),
        .out_ready (rdy_w[0]),
        .out_tok   (tok_w[0])
    );

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        fa25519_cell #(.IDX(k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld_w[k]),
            .in_ready  (rdy_w[k]),
            .in_tok    (tok_w[k]),
            .out_valid (vld_w[k+1]),
            .out_ready (rdy_w[k+1]),
            .out_tok   (tok_w[k+1])
        );
    end

    fa25519_canon u_canon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_w[NCELL]),
        .in_ready  (rdy_w[NCELL]),
        .in_acc    (tok_w[NCELL].acc),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_r     (r)
    );

    assign m_tdata = {1'b0, r};

endmodule

FILE: rtl/fa25519_prep.sv
// Operand front end: joins limbs, forms the multiplicand and multiplier words.
// Four elastic stages; depends on fa25519_pkg.
module fa25519_prep
    import fa25519_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   in_op,
    input  limbs_in_t         in_a,
    input  limbs_in_t         in_b,
    output logic              out_valid,
    input  logic              out_ready,
    output fa_tok_t           out_tok
);

    function automatic logic [JOIN_W-1:0] join_limbs(input limbs_in_t l);
        logic [254:0]        lo;
        logic [JOIN_W-1:0]   hi;
        hi = '0;
        lo = '0;
        for (int k = 0; k < NLIMB; k++) begin
            lo[LIMB_W*k +: LIMB_W]     = l[k][LIMB_W-1:0];
            hi[LIMB_W*k + LIMB_W +: 3] = l[k][IN_W-1:LIMB_W];
        end
        return {4'b0000, lo} + hi;
    endfunction

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              r1, r2, r3, r4;
    logic [OP_W-1:0]   op1_reg, op2_reg;
    logic [JOIN_W-1:0] a1_reg, b1_reg, a2_reg;
    logic [Y_W-1:0]    t2_next, t2_reg;
    logic [Y_W-1:0]    x3_next, x3_reg, y3_next, y3_reg;
    logic [X_W-1:0]    x4_next;
    fa_tok_t           tok4_reg;

    assign r4       = !v4_reg || out_ready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_comb begin
        t2_next = {1'b0, b1_reg};
        if (op1_reg == OP_SUB) begin
            t2_next = SIXTEEN_P - {1'b0, b1_reg};
        end
    end

    always_comb begin
        case (op2_reg)
            OP_ADD, OP_SUB: begin
                x3_next = {1'b0, a2_reg} + t2_reg;
                y3_next = Y_W'(1);
            end
            OP_MUL: begin
                x3_next = {1'b0, a2_reg};
                y3_next = t2_reg;
            end
            OP_SQR: begin
                x3_next = {1'b0, a2_reg};
                y3_next = {1'b0, a2_reg};
            end
            OP_RED: begin
                x3_next = {1'b0, a2_reg};
                y3_next = Y_W'(1);
            end
            default: begin
                x3_next = '0;
                y3_next = '0;
            end
        endcase
    end

    // fold bits at 2^255 and above back in by 19
    assign x4_next = {1'b0, x3_reg[254:0]}
                   + X_W'(10'(x3_reg[Y_W-1:255]) * 10'(FOLD));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            op1_reg <= in_op;
            a1_reg  <= join_limbs(in_a);
            b1_reg  <= join_limbs(in_b);
        end
        if (r2 && v1_reg) begin
            op2_reg <= op1_reg;
            a2_reg  <= a1_reg;
            t2_reg  <= t2_next;
        end
        if (r3 && v2_reg) begin
            x3_reg <= x3_next;
            y3_reg <= y3_next;
        end
        if (r4 && v3_reg) begin
            tok4_reg.x   <= x4_next;
            tok4_reg.acc <= '0;
            tok4_reg.y   <= y3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_tok   = tok4_reg;

endmodule

FILE: rtl/fa25519_cell.sv
// One cell of the multiply row: shifts the running sum by one digit mod p
// and adds multiplicand times its digit. Depends on fa25519_pkg.
module fa25519_cell
    import fa25519_pkg::*;
#(
    parameter int unsigned IDX = 0
)
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  fa_tok_t in_tok,
    output logic    out_valid,
    input  logic    out_ready,
    output fa_tok_t out_tok
);

    logic             valid_reg;
    fa_tok_t          tok_reg;
    logic [DIG_W-1:0] dig;
    logic [15:0]      top19;
    logic [Y_W-1:0]   xd;
    logic [ACC_W-1:0] acc_next;

    // most significant digit first
    assign dig   = in_tok.y[Y_W-1-DIG_W*IDX -: DIG_W];
    // acc * 16 = low * 16 + top * 2^255, and 2^255 == 19
    assign top19 = 16'(in_tok.acc[ACC_W-1:251]) * 16'(FOLD);
    assign xd    = Y_W'(in_tok.x) * Y_W'(dig);
    assign acc_next = ACC_W'({in_tok.acc[250:0], {DIG_W{1'b0}}})
                    + ACC_W'(top19) + ACC_W'(xd);

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            tok_reg.x   <= in_tok.x;
            tok_reg.y   <= in_tok.y;
            tok_reg.acc <= acc_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

FILE: rtl/fa25519_canon.sv
// Final reduction: two folds by 19 and a conditional subtract of p.
// Three elastic stages, the last is the output register. Depends on fa25519_pkg.
module fa25519_canon
    import fa25519_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ACC_W-1:0] in_acc,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [254:0]     out_r
);

    logic         v1_reg, v2_reg, v3_reg;
    logic         r1, r2, r3;
    logic [255:0] v_reg, v_next;
    logic [254:0] w_reg, w_next;
    logic [255:0] t;
    logic [254:0] r_reg, r_next;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    assign v_next = 256'(in_acc[254:0]) + 256'(12'(in_acc[ACC_W-1:255]) * 12'(FOLD));
    assign w_next = 255'(256'(v_reg[254:0]) + (v_reg[255] ? 256'(FOLD) : 256'd0));
    // value is below 2^255 here: subtract p when value + 19 reaches 2^255
    assign t      = 256'(w_reg) + 256'(FOLD);
    assign r_next = t[255] ? t[254:0] : w_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) v_reg <= v_next;
        if (r2 && v1_reg)   w_reg <= w_next;
        if (r3 && v2_reg)   r_reg <= r_next;
    end

    assign out_valid = v3_reg;
    assign out_r     = r_reg;

endmodule

FILE: rtl/fa25519_checker.sv
// Port-level checks for the field arithmetic core, attached by bind.
// Depends on fa25519_pkg and field_alu_mod_p25519_core.
module fa25519_checker
    import fa25519_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [255:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transfer changed");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_canonical: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata < P_VAL)
        else $error("result not below p");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind field_alu_mod_p25519_core fa25519_checker u_fa25519_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
